/* design/aes_cbc_pkg.sv */
// aes_cbc_pkg: shared types, constants, s-box tables and round functions
// for the aes-256 cbc cipher unit; no dependencies

package aes_cbc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY_A   = 3'd0,
    REG_KEY_B   = 3'd1,
    REG_KEY_C   = 3'd2,
    REG_KEY_D   = 3'd3,
    REG_IV_HI   = 3'd4,
    REG_IV_LO   = 3'd5,
    REG_DECRYPT = 3'd6
  } reg_idx_t;

  typedef logic [127:0] block_t;
  typedef logic [31:0]  word_t;

  localparam logic [7:0] GF_POLY   = 8'h1b;
  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [4:0] BLK_BYTES = 5'd16;
  localparam logic [3:0] LAST_ROUND = 4'd14;

  localparam logic [0:255][7:0] FWD_SBOX = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [0:255][7:0] INV_SBOX = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  // s-box on each byte of a key schedule word
  function automatic word_t subst_word(input word_t w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]],
            FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // forward column mix
  function automatic word_t mix_col(input word_t c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  // inverse column mix: coefficients 14, 11, 13, 9
  function automatic word_t imix_col(input word_t c);
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    a[0] = c[31:24]; a[1] = c[23:16]; a[2] = c[15:8]; a[3] = c[7:0];
    for (int j = 0; j < 4; j++) begin
      m2[j] = xt(a[j]);
      m4[j] = xt(m2[j]);
      m8[j] = xt(m4[j]);
      m9[j] = m8[j] ^ a[j];
      mb[j] = m9[j] ^ m2[j];
      md[j] = m9[j] ^ m4[j];
      me[j] = m8[j] ^ m4[j] ^ m2[j];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  // one forward step: initial key add, middle round or last round
  function automatic block_t enc_step(input block_t s, input block_t rk,
                                      input logic [3:0] step);
    block_t t;
    t = s;
    if (step != 4'd0) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[127 - 8 * (r + 4 * c) -: 8] =
            FWD_SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
      if (step != LAST_ROUND)
        for (int c = 0; c < 4; c++)
          t[127 - 32 * c -: 32] = mix_col(t[127 - 32 * c -: 32]);
    end
    return t ^ rk;
  endfunction

  // one inverse step: inverse shift and s-box (not on step 0), then key add, then inverse mix on middle rounds
  function automatic block_t dec_step(input block_t s, input block_t rk,
                                      input logic [3:0] step);
    block_t t;
    t = s;
    if (step != 4'd0)
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[127 - 8 * (r + 4 * c) -: 8] =
            INV_SBOX[s[127 - 8 * (r + 4 * ((c + 4 - r) % 4)) -: 8]];
    t = t ^ rk;
    if (step != 4'd0 && step != LAST_ROUND)
      for (int c = 0; c < 4; c++)
        t[127 - 32 * c -: 32] = imix_col(t[127 - 32 * c -: 32]);
    return t;
  endfunction

endpackage

/* design/aes_cbc_ifs.sv */
// aes_cbc channel interfaces: block input, result output, register writes
// depends on nothing

interface aes_cbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  logic        first_block;
  logic        last_block;
  logic [4:0]  byte_count;
  modport source (output valid, block_hi, block_lo, first_block, last_block, byte_count,
                  input ready);
  modport sink (input valid, block_hi, block_lo, first_block, last_block, byte_count,
                output ready);
endinterface

interface aes_cbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  logic        final_result;
  logic [4:0]  valid_bytes;
  logic        pad_error;
  modport source (output valid, result_hi, result_lo, final_result, valid_bytes, pad_error,
                  input ready);
  modport sink (input valid, result_hi, result_lo, final_result, valid_bytes, pad_error,
                output ready);
endinterface

interface aes_cbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/aes256_cbc_cipher_unit.sv */
// aes256_cbc_cipher_unit: aes-256 cbc with pkcs#7 pad/unpad, one round per cycle
// depends on aes_cbc_pkg and the interfaces in aes_cbc_ifs.sv
//
//  channel   dir   transfer carries
//  in_blk    in    block_hi/lo, first_block, last_block, byte_count
//  out_res   out   result_hi/lo, final_result, valid_bytes, pad_error
//  cfg_wr    in    index (0..6), data (64 bits); always ready
//
// a block runs through accept, key-row fetch, 15 steps of the shared round unit
// (initial key add plus 14 rounds) and result hand-off. a first block adds key
// expansion after the accept, one round-key word per cycle. an encrypt last block
// with 16 bytes runs the round unit twice. in_blk.ready is high only when idle;
// a stalled out_res holds the finished block. rst_n is synchronous and clears the
// state, out and extra flags, config and chain value; the round-key memory is not cleared.

module aes256_cbc_cipher_unit (
  input  logic          clk,
  input  logic          rst_n,
  aes_cbc_in_if.sink    in_blk,
  aes_cbc_out_if.source out_res,
  aes_cbc_cfg_if.sink   cfg_wr
);

  typedef enum logic [2:0] {ST_IDLE, ST_KEXP, ST_LOAD, ST_RUN, ST_FIN} state_t;

  state_t state_r;
  logic [63:0] key_r [4];
  logic [63:0] iv_hi_r, iv_lo_r;
  logic        dec_r;

  aes_cbc_pkg::block_t blk_r, chain_r, s_r, rk_q;
  logic        last_r, extra_r;
  logic [3:0]  k_r;
  logic [5:0]  i_r;
  logic [7:0]  rc_r;
  aes_cbc_pkg::word_t win_r [8];

  logic [63:0] res_hi_r, res_lo_r;
  logic        out_valid_r, final_r, err_r;
  logic [4:0]  vbytes_r;

  // round-key memory, one 128-bit row per round
  aes_cbc_pkg::block_t rk_mem [15];

  logic        in_acc, out_free;
  logic [4:0]  n_sat;
  aes_cbc_pkg::block_t padded, step_out, res;
  aes_cbc_pkg::word_t  kt, knew;
  logic        wr_en;
  logic [3:0]  wr_row, rd_row, rd_step;
  aes_cbc_pkg::block_t wr_data;
  logic [7:0]  pval;
  logic        perr;

  assign in_blk.ready = (state_r == ST_IDLE);
  assign in_acc       = in_blk.valid && in_blk.ready;
  assign out_free     = !out_valid_r || out_res.ready;
  assign cfg_wr.ready = 1'b1;

  assign out_res.valid        = out_valid_r;
  assign out_res.result_hi    = res_hi_r;
  assign out_res.result_lo    = res_lo_r;
  assign out_res.final_result = final_r;
  assign out_res.valid_bytes  = vbytes_r;
  assign out_res.pad_error    = err_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 4; j++) key_r[j] <= '0;
      iv_hi_r <= '0;
      iv_lo_r <= '0;
      dec_r   <= 1'b0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        aes_cbc_pkg::REG_KEY_A:   key_r[0] <= cfg_wr.data;
        aes_cbc_pkg::REG_KEY_B:   key_r[1] <= cfg_wr.data;
        aes_cbc_pkg::REG_KEY_C:   key_r[2] <= cfg_wr.data;
        aes_cbc_pkg::REG_KEY_D:   key_r[3] <= cfg_wr.data;
        aes_cbc_pkg::REG_IV_HI:   iv_hi_r  <= cfg_wr.data;
        aes_cbc_pkg::REG_IV_LO:   iv_lo_r  <= cfg_wr.data;
        aes_cbc_pkg::REG_DECRYPT: dec_r    <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  // pkcs#7 fill of the last encrypt block
  always_comb begin
    n_sat  = (in_blk.byte_count > aes_cbc_pkg::BLK_BYTES) ? aes_cbc_pkg::BLK_BYTES
                                                          : in_blk.byte_count;
    padded = {in_blk.block_hi, in_blk.block_lo};
    if (in_blk.last_block && !dec_r)
      for (int b = 0; b < 16; b++)
        if (5'(b) >= n_sat)
          padded[127 - 8 * b -: 8] = 8'(aes_cbc_pkg::BLK_BYTES - n_sat);
  end

  // key schedule word
  always_comb begin
    case (i_r[2:0])
      3'd0:    kt = aes_cbc_pkg::subst_word({win_r[7][23:0], win_r[7][31:24]})
                    ^ {rc_r, 24'h0};
      3'd4:    kt = aes_cbc_pkg::subst_word(win_r[7]);
      default: kt = win_r[7];
    endcase
    knew = win_r[0] ^ kt;
  end

  // round-key memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_row  = '0;
    wr_data = {key_r[0], key_r[1]};
    if (state_r == ST_IDLE && in_acc && in_blk.first_block) begin
      wr_en = 1'b1;
    end else if (state_r == ST_KEXP) begin
      if (i_r == 6'd8) begin
        wr_en   = 1'b1;
        wr_row  = 4'd1;
        wr_data = {win_r[4], win_r[5], win_r[6], win_r[7]};
      end else if (i_r[1:0] == 2'd3) begin
        wr_en   = 1'b1;
        wr_row  = i_r[5:2];
        wr_data = {win_r[5], win_r[6], win_r[7], knew};
      end
    end
  end

  // read address: row for the step that runs next
  always_comb begin
    rd_step = (state_r == ST_RUN) ? k_r + 4'd1 : 4'd0;
    if (rd_step > aes_cbc_pkg::LAST_ROUND) rd_step = aes_cbc_pkg::LAST_ROUND;
    rd_row = dec_r ? aes_cbc_pkg::LAST_ROUND - rd_step : rd_step;
  end

  always_ff @(posedge clk) begin
    if (wr_en) rk_mem[wr_row] <= wr_data;
    rk_q <= rk_mem[rd_row];
  end

  // shared round unit
  assign step_out = dec_r ? aes_cbc_pkg::dec_step(s_r, rk_q, k_r)
                          : aes_cbc_pkg::enc_step(s_r, rk_q, k_r);

  // finished block and padding check
  always_comb begin
    res  = dec_r ? (s_r ^ chain_r) : s_r;
    pval = res[7:0];
    perr = (pval == 8'h00) || (pval > 8'(aes_cbc_pkg::BLK_BYTES));
    for (int b = 0; b < 16; b++)
      if (!perr && 5'(b) >= aes_cbc_pkg::BLK_BYTES - pval[4:0] &&
          res[127 - 8 * b -: 8] != pval)
        perr = 1'b1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      chain_r     <= '0;
      extra_r     <= 1'b0;
    end else begin
      // result register fill and drain
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_res.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            blk_r   <= padded;
            last_r  <= in_blk.last_block;
            extra_r <= !dec_r && in_blk.last_block && n_sat == aes_cbc_pkg::BLK_BYTES;
            if (in_blk.first_block) begin
              chain_r <= {iv_hi_r, iv_lo_r};
              for (int j = 0; j < 4; j++) begin
                win_r[2 * j]     <= key_r[j][63:32];
                win_r[2 * j + 1] <= key_r[j][31:0];
              end
              i_r     <= 6'd8;
              rc_r    <= aes_cbc_pkg::RCON_INIT;
              state_r <= ST_KEXP;
            end else begin
              state_r <= ST_LOAD;
            end
          end
        end
        ST_KEXP: begin
          for (int j = 0; j < 7; j++) win_r[j] <= win_r[j + 1];
          win_r[7] <= knew;
          if (i_r[2:0] == 3'd0) rc_r <= aes_cbc_pkg::xt(rc_r);
          i_r <= i_r + 6'd1;
          if (i_r == 6'd59) state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          s_r     <= dec_r ? blk_r : (blk_r ^ chain_r);
          k_r     <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          s_r <= step_out;
          if (k_r == aes_cbc_pkg::LAST_ROUND) state_r <= ST_FIN;
          else k_r <= k_r + 4'd1;
        end
        ST_FIN: begin
          if (out_free) begin
            res_hi_r    <= res[127:64];
            res_lo_r    <= res[63:0];
            final_r     <= last_r && !extra_r;
            err_r       <= dec_r && last_r && perr;
            vbytes_r    <= (dec_r && last_r)
                           ? (perr ? 5'd0 : aes_cbc_pkg::BLK_BYTES - pval[4:0])
                           : aes_cbc_pkg::BLK_BYTES;
            chain_r     <= dec_r ? blk_r : res;
            if (extra_r) begin
              blk_r   <= {16{8'h10}};
              extra_r <= 1'b0;
              state_r <= ST_LOAD;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
